// File: src/aie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aie_pkg
// Shared types and opcode constants for the accumulator instruction executor.
// ----------------------------------------------------------------------------
package aie_pkg;

  localparam int DATA_W    = 16;
  localparam int OP_W      = 5;
  localparam int IDX_IN_W  = 3;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [OP_W-1:0] OP_HALT = 5'd0;
  localparam logic [OP_W-1:0] OP_SET  = 5'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 5'd2;
  localparam logic [OP_W-1:0] OP_SUB  = 5'd3;
  localparam logic [OP_W-1:0] OP_MUL  = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV  = 5'd5;
  localparam logic [OP_W-1:0] OP_AND  = 5'd6;
  localparam logic [OP_W-1:0] OP_OR   = 5'd7;
  localparam logic [OP_W-1:0] OP_XOR  = 5'd8;
  localparam logic [OP_W-1:0] OP_SHL  = 5'd9;
  localparam logic [OP_W-1:0] OP_SHR  = 5'd10;
  localparam logic [OP_W-1:0] OP_MOD  = 5'd11;
  localparam logic [OP_W-1:0] OP_JMP  = 5'd12;
  localparam logic [OP_W-1:0] OP_JE   = 5'd13;
  localparam logic [OP_W-1:0] OP_JNE  = 5'd14;
  localparam logic [OP_W-1:0] OP_JGEZ = 5'd15;
  localparam logic [OP_W-1:0] OP_CMP  = 5'd16;

  localparam logic [DATA_W-1:0] ALL_ONES = 16'hFFFF;
  localparam logic [DATA_W-1:0] PC_STEP  = 16'd2;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [IDX_IN_W-1:0] reg_index;
    logic [DATA_W-1:0]   operand;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] next_pc;
    logic [DATA_W-1:0] reg_value;
    logic              zero_flag;
    logic              halted;
    logic              div_by_zero;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// File: src/aie_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aie_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aie_divider (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire aie_pkg::div_ctrl_t ctrl,
  output aie_pkg::div_stat_t      stat
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [aie_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [aie_pkg::DATA_W-1:0]       rem_r, rem_nxt;
  logic [aie_pkg::DATA_W-1:0]       quo_r, quo_nxt;
  logic [aie_pkg::DATA_W-1:0]       dsr_r, dsr_nxt;
  logic [aie_pkg::DATA_W:0]         shifted;
  logic [aie_pkg::DATA_W:0]         trial;

  assign shifted = {rem_r, quo_r[aie_pkg::DATA_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = ctrl.dividend;
      dsr_nxt  = ctrl.divisor;
    end else if (busy_r) begin
      if (!trial[aie_pkg::DATA_W]) begin
        rem_nxt = trial[aie_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[aie_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[aie_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[aie_pkg::DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == aie_pkg::DIV_CNT_W'(aie_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy      = busy_r;
  assign stat.done      = done_r;
  assign stat.quotient  = quo_r;
  assign stat.remainder = rem_r;

endmodule

`default_nettype wire

// File: src/accumulator_instruction_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_instruction_execute
// Executes one decoded instruction per input word against a register file,
// program counter, zero flag and running flag; reports the state afterwards.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in_      | input     | in_valid / in_stall    | in_word  (opcode, reg_index, operand)
//  out_     | output    | out_valid / out_stall  | out_word (next_pc, reg_value, flags)
//
// One word at a time: accept, execute, present result.
// div and mod with a nonzero divisor, while running, also pass through the 16-step divider.
// in_stall is high from acceptance until the result word has been taken.
// Synchronous active-low reset clears registers, PC to START_ADDRESS, running on.
// ----------------------------------------------------------------------------
module accumulator_instruction_execute #(
  parameter int NUM_REGS      = 8,
  parameter int START_ADDRESS = 0
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire aie_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire                     out_stall,
  output aie_pkg::out_word_t      out_word
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int EXT_W = 5;

  aie_pkg::state_t   state_r, state_nxt;
  aie_pkg::in_word_t item_r;
  aie_pkg::out_word_t out_r;
  aie_pkg::div_ctrl_t div_ctrl;
  aie_pkg::div_stat_t div_stat;

  logic [aie_pkg::DATA_W-1:0] regs_r [NUM_REGS];
  logic [aie_pkg::DATA_W-1:0] pc_r, pc_nxt;
  logic                       zero_r, zero_nxt;
  logic                       running_r, running_nxt;

  logic [EXT_W-1:0]           idx_ext;
  logic [IDX_W-1:0]           idx;
  logic                       in_range;
  logic [aie_pkg::DATA_W-1:0] r_val, v_val, pc2;
  logic [aie_pkg::DATA_W-1:0] res;
  logic [2*aie_pkg::DATA_W-1:0] prod;
  logic                       writes, step2, dbz, need_div, commit, accept;
  logic [aie_pkg::DATA_W-1:0] reg_out;

  assign idx_ext  = EXT_W'(item_r.reg_index);
  assign idx      = idx_ext[IDX_W-1:0];
  assign in_range = idx_ext < EXT_W'(NUM_REGS);
  assign r_val    = in_range ? regs_r[idx] : '0;
  assign v_val    = item_r.operand;
  assign pc2      = pc_r + aie_pkg::PC_STEP;
  assign prod     = r_val * v_val;
  assign accept   = in_valid && !in_stall;

  assign need_div = running_r && (v_val != '0) &&
                    ((item_r.opcode == aie_pkg::OP_DIV) ||
                     (item_r.opcode == aie_pkg::OP_MOD));
  assign commit   = ((state_r == aie_pkg::ST_EXEC) && !need_div) ||
                    ((state_r == aie_pkg::ST_DIV) && div_stat.done);

  always_comb begin
    res         = r_val;
    writes      = 1'b0;
    step2       = 1'b1;
    dbz         = 1'b0;
    pc_nxt      = pc_r;
    zero_nxt    = zero_r;
    running_nxt = running_r;
    if (running_r) begin
      case (item_r.opcode)
        aie_pkg::OP_HALT: begin
          running_nxt = 1'b0;
          step2       = 1'b0;
        end
        aie_pkg::OP_SET: begin res = v_val;           writes = 1'b1; end
        aie_pkg::OP_ADD: begin res = r_val + v_val;   writes = 1'b1; end
        aie_pkg::OP_SUB: begin res = r_val - v_val;   writes = 1'b1; end
        aie_pkg::OP_MUL: begin res = prod[aie_pkg::DATA_W-1:0]; writes = 1'b1; end
        aie_pkg::OP_DIV: begin
          writes = 1'b1;
          if (v_val == '0) begin
            res = aie_pkg::ALL_ONES;
            dbz = 1'b1;
          end else begin
            res = div_stat.quotient;
          end
        end
        aie_pkg::OP_MOD: begin
          writes = 1'b1;
          if (v_val == '0) begin
            res = r_val;
            dbz = 1'b1;
          end else begin
            res = div_stat.remainder;
          end
        end
        aie_pkg::OP_AND: begin res = r_val & v_val; writes = 1'b1; end
        aie_pkg::OP_OR:  begin res = r_val | v_val; writes = 1'b1; end
        aie_pkg::OP_XOR: begin res = r_val ^ v_val; writes = 1'b1; end
        aie_pkg::OP_SHL: begin
          res    = (v_val[aie_pkg::DATA_W-1:4] != '0) ? '0 : (r_val << v_val[3:0]);
          writes = 1'b1;
        end
        aie_pkg::OP_SHR: begin
          res    = (v_val[aie_pkg::DATA_W-1:4] != '0) ? '0 : (r_val >> v_val[3:0]);
          writes = 1'b1;
        end
        aie_pkg::OP_JMP: begin pc_nxt = v_val; step2 = 1'b0; end
        aie_pkg::OP_JE: begin
          if (zero_r) begin pc_nxt = v_val; step2 = 1'b0; end
        end
        aie_pkg::OP_JNE: begin
          if (!zero_r) begin pc_nxt = v_val; step2 = 1'b0; end
        end
        aie_pkg::OP_JGEZ: begin
          if (!r_val[aie_pkg::DATA_W-1]) begin pc_nxt = v_val; step2 = 1'b0; end
        end
        aie_pkg::OP_CMP: zero_nxt = (r_val == v_val);
        default: step2 = 1'b0;
      endcase
      if (step2) begin
        pc_nxt = pc2;
      end
    end
  end

  assign reg_out = !in_range ? '0 : (writes ? res : r_val);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aie_pkg::ST_IDLE: if (accept) state_nxt = aie_pkg::ST_EXEC;
      aie_pkg::ST_EXEC: state_nxt = need_div ? aie_pkg::ST_DIV : aie_pkg::ST_OUT;
      aie_pkg::ST_DIV:  if (div_stat.done) state_nxt = aie_pkg::ST_OUT;
      aie_pkg::ST_OUT:  if (!out_stall) state_nxt = aie_pkg::ST_IDLE;
      default:          state_nxt = aie_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall          = 1'b1;
    out_valid         = 1'b0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = r_val;
    div_ctrl.divisor  = v_val;
    case (state_r)
      aie_pkg::ST_IDLE: in_stall = 1'b0;
      aie_pkg::ST_EXEC: div_ctrl.start = need_div;
      aie_pkg::ST_DIV:  ;
      aie_pkg::ST_OUT:  out_valid = 1'b1;
      default:          in_stall = 1'b1;
    endcase
  end

  aie_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= aie_pkg::ST_IDLE;
      pc_r      <= aie_pkg::DATA_W'(START_ADDRESS);
      zero_r    <= 1'b0;
      running_r <= 1'b1;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        pc_r      <= pc_nxt;
        zero_r    <= zero_nxt;
        running_r <= running_nxt;
        if (writes && in_range) begin
          regs_r[idx] <= res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_word;
    end
    if (commit) begin
      out_r.next_pc     <= pc_nxt;
      out_r.reg_value   <= reg_out;
      out_r.zero_flag   <= zero_nxt;
      out_r.halted      <= !running_nxt;
      out_r.div_by_zero <= dbz;
    end
  end

  assign out_word = out_r;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == aie_pkg::ST_DIV))
    else $error("divider finished outside divide state");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid)
    else $error("committed result not presented");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |=> !running_r)
    else $error("running flag set again after halt");
`endif

endmodule

`default_nettype wire
